// ===== sv/rpa_pkg.sv =====
// Shared types, constants and the corner offset function of the rectilinear path area block.
`default_nettype none

package rpa_pkg;

	// Coordinate width: default and the widest setting the term path is sized for.
	localparam int COORD_BITS_DEF  = 32;
	localparam int COORD_BITS_MAX  = 48;

	// Edge operands (dy and xs + xe) are one bit wider than a coordinate difference.
	localparam int TERM_W          = COORD_BITS_MAX + 2;

	// Multiplier operand width, split into two halves for the partial products.
	localparam int MAG_W           = 64;
	localparam int HALF_W          = MAG_W / 2;

	localparam int SUM_W           = 64;
	localparam int AREA_W          = 63;

	// Request and result field widths.
	localparam int DIR_W           = 2;
	localparam int DIST_W          = 20;
	localparam int COLOUR_W        = 24;
	localparam int DIGIT_W         = 4;
	localparam int S_TDATA_W       = 48;
	localparam int M_TDATA_W       = 64;
	localparam int M_TUSER_W       = 2;

	// Queue between the front and back ends, and the terms one request can carry.
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int TERMS_MAX       = 3;
	localparam int TERM_IDX_W      = 2;

	typedef enum logic [DIR_W-1:0] {
		DIR_RIGHT,
		DIR_DOWN,
		DIR_LEFT,
		DIR_UP
	} dir_t;

	typedef enum logic [1:0] {
		STATUS_OK,
		STATUS_BAD_DIGIT,
		STATUS_OVERFLOW
	} status_t;

	// Outer corner offset of a vertex.
	typedef struct packed {
		logic oy;
		logic ox;
	} offset_t;

	// One shoelace term: (ye - ys) * (xs + xe).
	typedef struct packed {
		logic [TERM_W-1:0] dy;
		logic [TERM_W-1:0] sx;
	} term_t;

	// One queued request: its terms in order, the first error it raised and its last flag.
	typedef struct packed {
		term_t [TERMS_MAX-1:0]  terms;
		logic [TERM_IDX_W-1:0]  count;
		status_t                err;
		logic                   last;
	} item_t;

	// Offset of the outer corner between two successive moves.
	function automatic offset_t corner(dir_t prev, dir_t cur);
		offset_t off;
		off = '0;
		if ((prev == DIR_RIGHT && cur == DIR_DOWN) || (prev == DIR_DOWN && cur == DIR_RIGHT)) begin
			off.ox = 1'b1;
		end else if ((prev == DIR_LEFT && cur == DIR_DOWN) ||
				(prev == DIR_DOWN && cur == DIR_LEFT)) begin
			off.ox = 1'b1;
			off.oy = 1'b1;
		end else if ((prev == DIR_LEFT && cur == DIR_UP) || (prev == DIR_UP && cur == DIR_LEFT)) begin
			off.oy = 1'b1;
		end
		return off;
	endfunction

endpackage

`default_nettype wire

// ===== sv/rpa_front.sv =====
// Front end: decodes each move, tracks cursor and vertices, and forms the shoelace terms.
`default_nettype none

module rpa_front #(
	parameter int COORD_BITS = rpa_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              decode_mode,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rpa_pkg::DIR_W-1:0]         direction,
	input  logic [rpa_pkg::DIST_W-1:0]        distance,
	input  logic [rpa_pkg::COLOUR_W-1:0]      colour,
	input  logic                              in_last,
	input  logic                              q_full,
	output logic                              push,
	output rpa_pkg::item_t                    push_item
);

	localparam int CB  = COORD_BITS;
	localparam int CW  = COORD_BITS + 1;
	localparam int TW  = rpa_pkg::TERM_W;
	localparam int EXT = TW - COORD_BITS;

	// Path state
	logic [CB-1:0]     cx_q, cy_q;
	logic [CB-1:0]     prior_x_q, prior_y_q;
	logic [CB-1:0]     second_x_q, second_y_q;
	rpa_pkg::dir_t     prev_dir_q, open_dir_q;
	logic [1:0]        seen_q;
	logic              ferr_q;

	logic [rpa_pkg::DIST_W-1:0] move_len;
	rpa_pkg::dir_t     dir;
	logic              bad;
	logic              accept;
	logic              first;
	rpa_pkg::offset_t  off, off_f;
	logic [CW-1:0]     vx_w, vy_w, nx_w, ny_w, cx_e, cy_e, dist_e;
	logic              vovf, covf;
	logic [CB-1:0]     vx, vy, s2x, s2y;
	logic              vtx_ok, edge_v, close_v;
	rpa_pkg::status_t  err_new;
	logic [TW-1:0]     vx_t, vy_t, px_t, py_t, fx_t, fy_t, s2x_t, s2y_t;
	rpa_pkg::term_t    edge_term, close1, close2;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept;
	assign first    = (seen_q == 2'd0);

	// Pick the move source according to the decode mode.
	always_comb begin
		if (decode_mode) begin
			move_len = colour[rpa_pkg::COLOUR_W-1:rpa_pkg::DIGIT_W];
			dir      = rpa_pkg::dir_t'(colour[rpa_pkg::DIR_W-1:0]);
			bad      = |colour[rpa_pkg::DIGIT_W-1:rpa_pkg::DIR_W];
		end else begin
			move_len = distance;
			dir      = rpa_pkg::dir_t'(direction);
			bad      = 1'b0;
		end
	end

	// Vertex on the outer corner, with its range check.
	assign off    = rpa_pkg::corner(prev_dir_q, dir);
	assign off_f  = rpa_pkg::corner(dir, open_dir_q);
	assign cx_e   = {cx_q[CB-1], cx_q};
	assign cy_e   = {cy_q[CB-1], cy_q};
	assign dist_e = CW'(move_len);
	assign vx_w   = cx_e + CW'(off.ox);
	assign vy_w   = cy_e + CW'(off.oy);
	assign vovf   = (vx_w[CB] ^ vx_w[CB-1]) | (vy_w[CB] ^ vy_w[CB-1]);
	assign vx     = vx_w[CB-1:0];
	assign vy     = vy_w[CB-1:0];

	// Cursor step along the move.
	always_comb begin
		nx_w = cx_e;
		ny_w = cy_e;
		unique case (dir)
			rpa_pkg::DIR_RIGHT: nx_w = cx_e + dist_e;
			rpa_pkg::DIR_DOWN:  ny_w = cy_e + dist_e;
			rpa_pkg::DIR_LEFT:  nx_w = cx_e - dist_e;
			rpa_pkg::DIR_UP:    ny_w = cy_e - dist_e;
		endcase
	end
	assign covf = (nx_w[CB] ^ nx_w[CB-1]) | (ny_w[CB] ^ ny_w[CB-1]);

	// First error raised by this move; none once the front end is already in error.
	always_comb begin
		priority if (ferr_q) begin
			err_new = rpa_pkg::STATUS_OK;
		end else if (bad) begin
			err_new = rpa_pkg::STATUS_BAD_DIGIT;
		end else if ((!first && vovf) || covf) begin
			err_new = rpa_pkg::STATUS_OVERFLOW;
		end else begin
			err_new = rpa_pkg::STATUS_OK;
		end
	end

	assign vtx_ok  = !ferr_q && !bad && !first && !vovf;
	assign edge_v  = vtx_ok && (seen_q == 2'd2);
	assign close_v = in_last && !ferr_q && !bad && !first && (err_new == rpa_pkg::STATUS_OK);

	// Operands widened to the term width.
	assign s2x   = (seen_q == 2'd1) ? vx : second_x_q;
	assign s2y   = (seen_q == 2'd1) ? vy : second_y_q;
	assign vx_t  = {{EXT{vx[CB-1]}}, vx};
	assign vy_t  = {{EXT{vy[CB-1]}}, vy};
	assign px_t  = {{EXT{prior_x_q[CB-1]}}, prior_x_q};
	assign py_t  = {{EXT{prior_y_q[CB-1]}}, prior_y_q};
	assign s2x_t = {{EXT{s2x[CB-1]}}, s2x};
	assign s2y_t = {{EXT{s2y[CB-1]}}, s2y};
	assign fx_t  = TW'(off_f.ox);
	assign fy_t  = TW'(off_f.oy);

	// Edge into the new vertex, then both edges through the deferred first vertex.
	assign edge_term.dy = vy_t - py_t;
	assign edge_term.sx = px_t + vx_t;
	assign close1.dy    = fy_t - vy_t;
	assign close1.sx    = vx_t + fx_t;
	assign close2.dy    = s2y_t - fy_t;
	assign close2.sx    = fx_t + s2x_t;

	// Pack the request for the back end, terms in the order they are summed.
	always_comb begin
		push_item      = '0;
		push_item.err  = err_new;
		push_item.last = in_last;
		if (edge_v) begin
			push_item.terms[0] = edge_term;
			push_item.terms[1] = close1;
			push_item.terms[2] = close2;
			push_item.count    = close_v ? 2'd3 : 2'd1;
		end else begin
			push_item.terms[0] = close1;
			push_item.terms[1] = close2;
			push_item.terms[2] = close2;
			push_item.count    = close_v ? 2'd2 : 2'd0;
		end
	end

	// Path state update; the closing move returns everything to its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q       <= '0;
			cy_q       <= '0;
			prior_x_q  <= '0;
			prior_y_q  <= '0;
			second_x_q <= '0;
			second_y_q <= '0;
			prev_dir_q <= rpa_pkg::DIR_RIGHT;
			open_dir_q <= rpa_pkg::DIR_RIGHT;
			seen_q     <= 2'd0;
			ferr_q     <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				cx_q       <= '0;
				cy_q       <= '0;
				prior_x_q  <= '0;
				prior_y_q  <= '0;
				second_x_q <= '0;
				second_y_q <= '0;
				prev_dir_q <= rpa_pkg::DIR_RIGHT;
				open_dir_q <= rpa_pkg::DIR_RIGHT;
				seen_q     <= 2'd0;
				ferr_q     <= 1'b0;
			end else begin
				if (err_new != rpa_pkg::STATUS_OK) begin
					ferr_q <= 1'b1;
				end
				if (!ferr_q && !bad) begin
					prev_dir_q <= dir;
					if (seen_q != 2'd2) begin
						seen_q <= seen_q + 2'd1;
					end
					if (first) begin
						open_dir_q <= dir;
					end
					if (vtx_ok) begin
						prior_x_q <= vx;
						prior_y_q <= vy;
						if (seen_q == 2'd1) begin
							second_x_q <= vx;
							second_y_q <= vy;
						end
					end
					if (first || !vovf) begin
						cx_q <= nx_w[CB-1:0];
						cy_q <= ny_w[CB-1:0];
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/rpa_queue.sv =====
// Short request queue between the front and back ends.
`default_nettype none

module rpa_queue #(
	parameter int DEPTH = rpa_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rpa_pkg::item_t  push_item,
	output logic            full,
	input  logic            pop,
	output rpa_pkg::item_t  head,
	output logic            not_empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rpa_pkg::item_t    entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/rpa_back.sv =====
// Back end: multiplies and accumulates the shoelace terms and delivers the area result.
`default_nettype none

module rpa_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rpa_pkg::item_t                head,
	input  logic                          head_valid,
	output logic                          pop,
	output logic                          m_valid,
	input  logic                          m_ready,
	output logic [rpa_pkg::AREA_W-1:0]    area,
	output rpa_pkg::status_t              status
);

	localparam int TW   = rpa_pkg::TERM_W;
	localparam int MW   = rpa_pkg::MAG_W;
	localparam int HW   = rpa_pkg::HALF_W;
	localparam int SW   = rpa_pkg::SUM_W;
	localparam int IW   = rpa_pkg::TERM_IDX_W;
	localparam int PW   = MW + HW + 2;

	typedef struct packed {
		logic              valid;
		logic              term;
		logic              neg;
		rpa_pkg::status_t  err;
		logic              emit;
	} op_ctl_t;

	logic              adv, issue, op_last;
	logic [IW-1:0]     sub_q, last_idx;
	rpa_pkg::term_t    term_sel;
	logic [TW-1:0]     ma, mb;
	op_ctl_t           ctl_in, ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;

	logic [MW-1:0]     ma_s1, mb_s1;
	logic [MW-1:0]     pp_ll_s2, pp_lh_s2, pp_hl_s2, pp_hh_s2;
	logic [MW:0]       mid_s3;
	logic [MW-1:0]     ll_s3;
	logic              hhnz_s3;
	logic [PW-1:0]     prod_w;
	logic [MW-1:0]     prod_s4;
	logic              ovf_s4, ovf_s5;
	logic [SW-1:0]     v_s5;

	logic [SW-1:0]     sum_q, acc_sum;
	rpa_pkg::status_t  err_q, acc_err;
	logic [SW:0]       sum_w;
	logic              fin_valid_s6;
	logic [SW-1:0]     fin_sum_s6, fin_mag;
	rpa_pkg::status_t  fin_err_s6;

	logic                        m_valid_q;
	logic [rpa_pkg::AREA_W-1:0]  area_q;
	rpa_pkg::status_t            status_q;

	// The whole back pipeline moves unless a finished result is waiting.
	assign adv      = !m_valid_q || m_ready;
	assign last_idx = (head.count == '0) ? '0 : head.count - IW'(1);
	assign op_last  = (sub_q == last_idx);
	assign issue    = head_valid && adv;
	assign pop      = issue && op_last;
	assign term_sel = head.terms[sub_q];

	// One term a cycle unless stalled; error and result flags ride on the last one.
	assign ma = term_sel.dy[TW-1] ? TW'(-term_sel.dy) : term_sel.dy;
	assign mb = term_sel.sx[TW-1] ? TW'(-term_sel.sx) : term_sel.sx;
	always_comb begin
		ctl_in       = '0;
		ctl_in.valid = head_valid;
		ctl_in.term  = (sub_q < head.count);
		ctl_in.neg   = term_sel.dy[TW-1] ^ term_sel.sx[TW-1];
		ctl_in.err   = op_last ? head.err : rpa_pkg::STATUS_OK;
		ctl_in.emit  = op_last && head.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= '0;
		end else if (issue) begin
			sub_q <= op_last ? '0 : sub_q + IW'(1);
		end
	end

	// Stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// Magnitude product: partial products, middle sum, assembly and sign.
	assign prod_w = PW'({mid_s3, {HW{1'b0}}}) + PW'(ll_s3);
	always_ff @(posedge clk) begin
		if (adv) begin
			ma_s1    <= MW'(ma);
			mb_s1    <= MW'(mb);
			pp_ll_s2 <= ma_s1[HW-1:0] * mb_s1[HW-1:0];
			pp_lh_s2 <= ma_s1[HW-1:0] * mb_s1[MW-1:HW];
			pp_hl_s2 <= ma_s1[MW-1:HW] * mb_s1[HW-1:0];
			pp_hh_s2 <= ma_s1[MW-1:HW] * mb_s1[MW-1:HW];
			mid_s3   <= {1'b0, pp_lh_s2} + {1'b0, pp_hl_s2};
			ll_s3    <= pp_ll_s2;
			hhnz_s3  <= |pp_hh_s2;
			prod_s4  <= prod_w[MW-1:0];
			ovf_s4   <= hhnz_s3 | (|prod_w[PW-1:SW-1]);
			v_s5     <= ctl_s4.neg ? SW'(-prod_s4) : SW'(prod_s4);
			ovf_s5   <= ovf_s4;
		end
	end

	// Accumulate with overflow check; the first error seen is kept.
	assign sum_w = {sum_q[SW-1], sum_q} + {v_s5[SW-1], v_s5};
	always_comb begin
		acc_err = err_q;
		acc_sum = sum_q;
		if (err_q == rpa_pkg::STATUS_OK && ctl_s5.term) begin
			if (ovf_s5 || (sum_w[SW] ^ sum_w[SW-1])) begin
				acc_err = rpa_pkg::STATUS_OVERFLOW;
			end else begin
				acc_sum = sum_w[SW-1:0];
			end
		end
		if (acc_err == rpa_pkg::STATUS_OK && ctl_s5.err != rpa_pkg::STATUS_OK) begin
			acc_err = ctl_s5.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			err_q <= rpa_pkg::STATUS_OK;
		end else if (adv && ctl_s5.valid) begin
			if (ctl_s5.emit) begin
				sum_q <= '0;
				err_q <= rpa_pkg::STATUS_OK;
			end else begin
				sum_q <= acc_sum;
				err_q <= acc_err;
			end
		end
	end

	// Final sum of a closed path.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_s6 <= 1'b0;
		end else if (adv) begin
			fin_valid_s6 <= ctl_s5.valid && ctl_s5.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fin_sum_s6 <= acc_sum;
			fin_err_s6 <= acc_err;
		end
	end

	// Output register: halved magnitude, or zero with the error status.
	assign fin_mag = fin_sum_s6[SW-1] ? SW'(-fin_sum_s6) : fin_sum_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= fin_valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fin_valid_s6) begin
			area_q   <= (fin_err_s6 == rpa_pkg::STATUS_OK) ? fin_mag[SW-1:1] : '0;
			status_q <= fin_err_s6;
		end
	end

	assign m_valid = m_valid_q;
	assign area    = area_q;
	assign status  = status_q;

	// Checks
	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("request popped from an empty queue");

	a_error_zero_area: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && status_q != rpa_pkg::STATUS_OK) |-> (area_q == '0))
		else $error("error result carries a nonzero area");

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ctl_s5.valid && ctl_s5.emit) |=> (err_q == rpa_pkg::STATUS_OK && sum_q == '0))
		else $error("accumulator not cleared after a result");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != rpa_pkg::STATUS_OK && !(adv && ctl_s5.valid && ctl_s5.emit))
		|=> (err_q == $past(err_q)))
		else $error("recorded error changed before the path closed");

	a_term_index: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q < IW'(rpa_pkg::TERMS_MAX))
		else $error("term index beyond the terms of one request");

endmodule

`default_nettype wire

// ===== sv/rectilinear_path_area.sv =====
// Top level of the rectilinear path area block: mode register, front end, queue and back end.
// Result path: a closing request is queued, then its terms pass back-end stages s1 to s5,
// the accumulator and the final-sum and output registers, and may wait in the queue or at the output.
// Throughput: one request per cycle while the queue is not full; the back end takes one shoelace term
// per cycle unless its output stalls, and a request's terms enter it one after another.
// Reset: arst_n clears path state, queue, pipeline and output asynchronously; decode mode is 0.
`default_nettype none

module rectilinear_path_area #(
	parameter int COORD_BITS  = rpa_pkg::COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = rpa_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration: decode mode
	input  logic                               cfg_we,
	input  logic                               cfg_wdata,
	// Moves in
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [rpa_pkg::S_TDATA_W-1:0]      s_tdata,   // direction[1:0], distance[21:2], colour[45:22]
	input  logic                               s_tlast,   // closing move
	// Results out
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [rpa_pkg::M_TDATA_W-1:0]      m_tdata,   // area[62:0]
	output logic [rpa_pkg::M_TUSER_W-1:0]      m_tuser    // status[1:0]
);

	localparam int DIR_LO    = 0;
	localparam int DIST_LO   = DIR_LO + rpa_pkg::DIR_W;
	localparam int COLOUR_LO = DIST_LO + rpa_pkg::DIST_W;

	logic                         decode_mode_q;
	logic                         q_full, q_not_empty, push, pop;
	rpa_pkg::item_t               push_item, head;
	logic [rpa_pkg::AREA_W-1:0]   area;
	rpa_pkg::status_t             status;

	// Decode mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= 1'b0;
		end else if (cfg_we) begin
			decode_mode_q <= cfg_wdata;
		end
	end

	rpa_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.decode_mode (decode_mode_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.direction   (s_tdata[DIST_LO-1:DIR_LO]),
		.distance    (s_tdata[COLOUR_LO-1:DIST_LO]),
		.colour      (s_tdata[COLOUR_LO+rpa_pkg::COLOUR_W-1:COLOUR_LO]),
		.in_last     (s_tlast),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	rpa_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.not_empty (q_not_empty)
	);

	rpa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (q_not_empty),
		.pop        (pop),
		.m_valid    (m_tvalid),
		.m_ready    (m_tready),
		.area       (area),
		.status     (status)
	);

	assign m_tdata = {{(rpa_pkg::M_TDATA_W - rpa_pkg::AREA_W){1'b0}}, area};
	assign m_tuser = status;

endmodule

`default_nettype wire

// ===== tb/sv/rectilinear_path_area_test.sv =====
// Self-checking testbench for the rectilinear path area block, with its own area predictor.
`timescale 1ns / 1ps

module rectilinear_path_area_test;
	import rpa_pkg::*;

	localparam int COORD_W = COORD_BITS_DEF;
	localparam longint COORD_HI = (longint'(1) << (COORD_W - 1)) - 1;
	localparam longint COORD_LO = -COORD_HI - 1;
	localparam longint I64_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint I64_LO = -I64_HI - 1;
	localparam int unsigned LEN_MAX = (1 << DIST_W) - 1;
	localparam int SETTLE_CYCLES = 20;

	// One move request as queued for the driver.
	typedef struct {
		dir_t                  direction;
		logic [DIST_W-1:0]     distance;
		logic [COLOUR_W-1:0]   colour;
		logic                  last;
		bit                    hold;
	} move_t;

	// One area result as the block should report it.
	typedef struct {
		logic [AREA_W-1:0] area;
		status_t           status;
	} area_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic                 cfg_wdata = 1'b0;
	logic                 s_tvalid = 1'b0;
	wire                  s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tlast = 1'b0;
	wire                  m_tvalid;
	logic                 m_tready = 1'b0;
	wire [M_TDATA_W-1:0]  m_tdata;
	wire [M_TUSER_W-1:0]  m_tuser;

	move_t        pending_moves[$];
	area_result_t area_expect[$];
	move_t        cur_move;
	int           moves_queued = 0;
	int           moves_taken = 0;
	int           paths_made = 0;
	int           mismatches = 0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;

	// Mirror of the block's path state and mode register.
	bit      decode_colour;
	longint  pos_x, pos_y;
	dir_t    heading, opening;
	int      moves_in_path;
	longint  corner_x, corner_y;
	longint  anchor_x, anchor_y;
	longint  twice_area;
	status_t path_fault;

	rectilinear_path_area u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// Clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor.

	function automatic void reset_path();
		pos_x = 0;
		pos_y = 0;
		heading = DIR_RIGHT;
		opening = DIR_RIGHT;
		moves_in_path = 0;
		corner_x = 0;
		corner_y = 0;
		anchor_x = 0;
		anchor_y = 0;
		twice_area = 0;
		path_fault = STATUS_OK;
	endfunction

	function automatic void raise_fault(status_t code);
		if (path_fault == STATUS_OK) begin
			path_fault = code;
		end
	endfunction

	function automatic bit fits_coord(longint v);
		return v >= COORD_LO && v <= COORD_HI;
	endfunction

	// The vertex sits on the outer corner of the turn between two headings.
	function automatic void outer_offset(dir_t from_dir, dir_t to_dir, output longint ox,
			output longint oy);
		ox = 0;
		oy = 0;
		case ({from_dir, to_dir})
			{DIR_RIGHT, DIR_DOWN}, {DIR_DOWN, DIR_RIGHT}: begin
				ox = 1;
			end
			{DIR_LEFT, DIR_DOWN}, {DIR_DOWN, DIR_LEFT}: begin
				ox = 1;
				oy = 1;
			end
			{DIR_LEFT, DIR_UP}, {DIR_UP, DIR_LEFT}: begin
				oy = 1;
			end
			default: begin
			end
		endcase
	endfunction

	// Adds one trapezoid term to the doubled area; returns 0 if the term or the sum overflows.
	function automatic bit add_trapezoid(longint xs, longint ys, longint xe, longint ye);
		logic signed [127:0] dy, sx, term, total;
		dy = ye - ys;
		sx = xs + xe;
		term = dy * sx;
		if (term > I64_HI || term < -I64_HI) begin
			return 1'b0;
		end
		total = term + twice_area;
		if (total > I64_HI || total < I64_LO) begin
			return 1'b0;
		end
		twice_area = total[63:0];
		return 1'b1;
	endfunction

	function automatic void predict_move(move_t m);
		dir_t         d;
		longint       len, ox, oy, vx, vy;
		bit           usable;
		int           seen;
		area_result_t r;
		logic [63:0]  mag;
		d = m.direction;
		len = longint'(m.distance);
		usable = 1'b1;
		seen = moves_in_path;
		if (decode_colour) begin
			len = longint'(m.colour[COLOUR_W-1:DIGIT_W]);
			if (m.colour[DIGIT_W-1:0] > 3) begin
				raise_fault(STATUS_BAD_DIGIT);
				usable = 1'b0;
			end
			d = dir_t'(m.colour[DIR_W-1:0]);
		end
		if (usable && path_fault == STATUS_OK) begin
			if (seen == 0) begin
				opening = d;
			end else begin
				outer_offset(heading, d, ox, oy);
				vx = pos_x + ox;
				vy = pos_y + oy;
				if (!fits_coord(vx) || !fits_coord(vy)) begin
					raise_fault(STATUS_OVERFLOW);
				end else begin
					if (seen == 1) begin
						anchor_x = vx;
						anchor_y = vy;
					end else if (!add_trapezoid(corner_x, corner_y, vx, vy)) begin
						raise_fault(STATUS_OVERFLOW);
					end
					corner_x = vx;
					corner_y = vy;
				end
			end
			if (path_fault == STATUS_OK) begin
				case (d)
					DIR_RIGHT: pos_x += len;
					DIR_DOWN:  pos_y += len;
					DIR_LEFT:  pos_x -= len;
					default:   pos_y -= len;
				endcase
				if (!fits_coord(pos_x) || !fits_coord(pos_y)) begin
					raise_fault(STATUS_OVERFLOW);
				end
			end
			heading = d;
			if (moves_in_path < 2) begin
				moves_in_path++;
			end
		end
		if (!m.last) begin
			return;
		end
		// Closing move: place the deferred first vertex and close both edges through it.
		if (path_fault == STATUS_OK && moves_in_path >= 2) begin
			outer_offset(heading, opening, ox, oy);
			if (!add_trapezoid(corner_x, corner_y, ox, oy)) begin
				raise_fault(STATUS_OVERFLOW);
			end else if (!add_trapezoid(ox, oy, anchor_x, anchor_y)) begin
				raise_fault(STATUS_OVERFLOW);
			end
		end
		if (path_fault == STATUS_OK) begin
			mag = twice_area < 0 ? -twice_area : twice_area;
			mag = mag >> 1;
			r.area = mag[AREA_W-1:0];
			r.status = STATUS_OK;
		end else begin
			r.area = '0;
			r.status = path_fault;
		end
		area_expect.insert(area_expect.size(), r);
		reset_path();
	endfunction

	// Checking.

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic check_result(logic [AREA_W-1:0] area, logic [M_TUSER_W-1:0] status);
		area_result_t want;
		if (area_expect.size() == 0) begin
			report_mismatch("result with no path closed", 64'(area), '0);
		end else begin
			want = area_expect.pop_front();
			if (area !== want.area) begin
				report_mismatch("area", 64'(area), 64'(want.area));
			end
			if (status !== want.status) begin
				report_mismatch("status", 64'(status), 64'(want.status));
			end
		end
	endtask

	// Driver: presents queued moves, idles at random and holds a marked move until every
	// closed path has reported.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_move(cur_move);
				moves_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_moves.size() != 0 && $urandom_range(99) >= send_idle_pct &&
						(!pending_moves[0].hold || area_expect.size() == 0)) begin
					cur_move = pending_moves.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, cur_move.colour, cur_move.distance, cur_move.direction};
					s_tlast <= cur_move.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: takes results with random back-pressure and checks each one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result(m_tdata[AREA_W-1:0], m_tuser);
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Stimulus helpers.

	function automatic move_t make_step(dir_t d, int unsigned len, bit last);
		move_t m;
		m.direction = dir_t'($urandom_range(3));
		m.distance = DIST_W'($urandom);
		m.colour = COLOUR_W'($urandom);
		m.last = last;
		m.hold = 1'b0;
		if (decode_colour) begin
			m.colour = {len[DIST_W-1:0], 2'b00, d};
		end else begin
			m.direction = d;
			m.distance = len[DIST_W-1:0];
		end
		return m;
	endfunction

	function automatic void queue_move(move_t m);
		pending_moves.insert(pending_moves.size(), m);
		moves_queued++;
	endfunction

	function automatic void queue_colour(logic [COLOUR_W-1:0] colour, bit last);
		move_t m;
		m = make_step(DIR_RIGHT, 0, last);
		m.colour = colour;
		queue_move(m);
	endfunction

	// A random walk closed by one horizontal and one vertical move; in colour mode a move
	// is now and then given a bad direction digit.
	function automatic void add_closed_path();
		int          n, scale, i;
		longint      px, py;
		dir_t        d;
		int unsigned len;
		move_t       m;
		n = $urandom_range(2, 8);
		px = 0;
		py = 0;
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: scale = 16;
			6, 7, 8:          scale = 4095;
			default:          scale = 100000;
		endcase
		for (i = 0; i < n; i++) begin
			d = dir_t'($urandom_range(3));
			len = $urandom_range(scale);
			m = make_step(d, len, 1'b0);
			if (decode_colour && $urandom_range(24) == 0) begin
				m.colour[DIGIT_W-1:0] = DIGIT_W'($urandom_range(4, 15));
			end
			queue_move(m);
			case (d)
				DIR_RIGHT: px += len;
				DIR_DOWN:  py += len;
				DIR_LEFT:  px -= len;
				default:   py -= len;
			endcase
		end
		queue_move(make_step(px > 0 ? DIR_LEFT : DIR_RIGHT, 32'(px > 0 ? px : -px), 1'b0));
		queue_move(make_step(py > 0 ? DIR_UP : DIR_DOWN, 32'(py > 0 ? py : -py), 1'b1));
	endfunction

	function automatic void add_random_path();
		int    idx, n, i, kind;
		move_t m;
		idx = pending_moves.size();
		kind = $urandom_range(99);
		if (kind < 70) begin
			add_closed_path();
		end else if (kind < 85) begin
			// Noise: every field random, whatever the mode.
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++) begin
				m.direction = dir_t'($urandom_range(3));
				m.distance = DIST_W'($urandom);
				m.colour = COLOUR_W'($urandom);
				m.last = (i == n - 1);
				m.hold = 1'b0;
				queue_move(m);
			end
		end else begin
			// Paths of one or two moves, whose terms cancel.
			n = $urandom_range(1, 2);
			for (i = 0; i < n; i++) begin
				queue_move(make_step(dir_t'($urandom_range(3)), $urandom_range(LEN_MAX),
						i == n - 1));
			end
		end
		if (paths_made % 30 == 7) begin
			pending_moves[idx].hold = 1'b1;
		end
		paths_made++;
	endfunction

	task automatic add_random_moves(int count);
		int target;
		target = moves_queued + count;
		while (moves_queued < target) add_random_path();
	endtask

	// Waits until every move is taken and every result is in, then lets the block settle.
	task automatic drain();
		while (moves_taken != moves_queued || area_expect.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(bit mode);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		decode_colour = mode;
	endtask

	// Sequence of phases.
	initial begin
		decode_colour = 1'b0;
		reset_path();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 12;
		recv_idle_pct = 71;
		write_mode(1'b0);

		// Direct fields: single move, two moves, unit square, full-length square and an
		// anticlockwise rectangle.
		queue_move(make_step(DIR_RIGHT, LEN_MAX, 1'b1));
		queue_move(make_step(DIR_DOWN, 0, 1'b0));
		queue_move(make_step(DIR_UP, LEN_MAX, 1'b1));
		queue_move(make_step(DIR_RIGHT, 1, 1'b0));
		queue_move(make_step(DIR_DOWN, 1, 1'b0));
		queue_move(make_step(DIR_LEFT, 1, 1'b0));
		queue_move(make_step(DIR_UP, 1, 1'b1));
		queue_move(make_step(DIR_RIGHT, LEN_MAX, 1'b0));
		queue_move(make_step(DIR_DOWN, LEN_MAX, 1'b0));
		queue_move(make_step(DIR_LEFT, LEN_MAX, 1'b0));
		queue_move(make_step(DIR_UP, LEN_MAX, 1'b1));
		queue_move(make_step(DIR_DOWN, 2, 1'b0));
		queue_move(make_step(DIR_RIGHT, 3, 1'b0));
		queue_move(make_step(DIR_UP, 2, 1'b0));
		queue_move(make_step(DIR_LEFT, 3, 1'b1));
		drain();

		// Colour words: a full-length path, bad digits mid-path and a bad digit alone.
		write_mode(1'b1);
		queue_colour(24'hFFFFF0, 1'b0);
		queue_colour(24'h000011, 1'b0);
		queue_colour(24'hFFFFF2, 1'b0);
		queue_colour(24'h000013, 1'b1);
		queue_colour(24'h000050, 1'b0);
		queue_colour(24'hFFFFFF, 1'b0);
		queue_colour(24'h000054, 1'b0);
		queue_colour(24'h000031, 1'b1);
		queue_colour(24'hABCDE7, 1'b1);
		add_random_moves(625);
		drain();

		send_idle_pct = 71;
		recv_idle_pct = 12;
		write_mode(1'b0);
		add_random_moves(625);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_mode(1'b1);
		add_random_moves(310);
		drain();

		write_mode(1'b0);
		add_random_moves(310);
		drain();

		if (mismatches == 0) begin
			$display("[rectilinear_path_area] OK");
		end else begin
			$display("[rectilinear_path_area] ERROR");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#2_000_000;
		$display("[rectilinear_path_area] ERROR");
		$finish;
	end

endmodule
